// ===== sv/polist_pkg.sv =====
// ----------------------------------------------------------------------------
// polist_pkg
// Shared types and codes for the positional ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package polist_pkg;

    // command codes (input tuser)
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int POS_W = 5;
    localparam int VAL_W = 32;

    // verdict of the position checker
    typedef struct packed {
        logic [1:0] status;    // ST_* code
        logic       ok;        // operation goes ahead
        logic       to_empty;  // add into an empty list
    } t_chk;

endpackage

`default_nettype wire

// ===== sv/polist_chk.sv =====
// ----------------------------------------------------------------------------
// polist_chk
// Validates one command against the current list fill.
// ----------------------------------------------------------------------------
`default_nettype none

module polist_chk
    import polist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                             i_command,
    input  wire logic [POS_W-1:0]                 i_position,
    input  wire logic [$clog2(CAPACITY+1)-1:0]    i_count,
    output t_chk                                  o_chk
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    logic          w_full;
    logic          w_empty;
    logic          w_pos_bad;

    assign w_pos     = PW'(i_position);
    assign w_cnt     = PW'(i_count);
    assign w_full    = (w_cnt >= PW'(CAPACITY));
    assign w_empty   = (w_cnt == '0);
    assign w_pos_bad = (w_pos == '0) || (w_pos > w_cnt);

    always_comb begin
        o_chk.to_empty = 1'b0;
        o_chk.status   = ST_OK;
        if (i_command == CMD_ADD) begin
            if (w_full) begin
                o_chk.status = ST_FULL;
            end else if (w_empty) begin
                o_chk.to_empty = 1'b1;
            end else if (w_pos_bad) begin
                o_chk.status = ST_BAD_POS;
            end
        end else begin
            if (w_empty) begin
                o_chk.status = ST_EMPTY;
            end else if (w_pos_bad) begin
                o_chk.status = ST_BAD_POS;
            end
        end
        o_chk.ok = (o_chk.status == ST_OK);
    end

endmodule

`default_nettype wire

// ===== sv/positional_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_engine
// Bounded ordered list of signed words with positional insert and delete.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY signed 32-bit words in a single-port-write,
// registered-read memory. Each slave transaction is one add or delete; the
// block drops s_axis_tready until that transaction's whole result run has
// left on the master side. A rejected command yields one result carrying the
// error status. A successful one moves the tail of the list one slot per
// cycle through the memory port (pipelined read then write), drains that
// pipeline, passes through S_FIN and S_PRIME to finish and prime the read,
// then streams the list head to tail, one element per cycle while
// m_axis_tready is high, tlast on the final element (an emptied list gives
// one result with element_valid low and skips S_PRIME). An add into an
// empty list writes slot 0 directly and goes straight to S_PRIME.
// There is no clearing pass: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list_engine
    import polist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [31:0] value, [36:32] position, [37] after, [39:38] zero
    input  wire logic [39:0] i_s_axis_tdata,
    // [0] command
    input  wire logic [0:0]  i_s_axis_tuser,
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] element, [36:32] list_count, [39:37] zero
    output logic [39:0]      o_m_axis_tdata,
    // [1:0] status, [2] element_valid
    output logic [2:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_FIN    = 3'd2;
    localparam logic [2:0] S_PRIME  = 3'd3;
    localparam logic [2:0] S_STREAM = 3'd4;

    // list storage, no reset
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd;

    logic [2:0]       r_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_left;     // shift reads still to issue
    logic [AW-1:0]    r_src;      // next shift read address
    logic [AW-1:0]    r_pdst;     // destination of the read in flight
    logic             r_pend;     // shift read in flight
    logic             r_dir;      // 0 move up (insert), 1 move down (delete)
    logic             r_ins;      // insert pending at r_idx
    logic [AW-1:0]    r_idx;
    logic [VAL_W-1:0] r_val;
    logic [AW-1:0]    r_j;        // stream read pointer
    logic             r_ovld;
    logic             r_ev;
    logic [1:0]       r_status;

    // input fields
    logic             w_cmd;
    logic [VAL_W-1:0] w_value;
    logic [POS_W-1:0] w_position;
    logic             w_after;
    t_chk             w_chk;

    assign w_cmd      = i_s_axis_tuser[0];
    assign w_value    = i_s_axis_tdata[31:0];
    assign w_position = i_s_axis_tdata[36:32];
    assign w_after    = i_s_axis_tdata[37];

    polist_chk #(
        .CAPACITY (CAPACITY)
    ) u_chk (
        .i_command  (w_cmd),
        .i_position (w_position),
        .i_count    (r_cnt),
        .o_chk      (w_chk)
    );

    // position arithmetic at a width holding both count and position
    logic [PW-1:0] w_pos_w;
    logic [PW-1:0] w_cnt_w;
    logic [PW-1:0] w_idx_w;
    logic [PW-1:0] w_ileft_w;
    logic [PW-1:0] w_dleft_w;
    logic [PW-1:0] w_cntm1_w;

    assign w_pos_w   = PW'(w_position);
    assign w_cnt_w   = PW'(r_cnt);
    assign w_idx_w   = w_after ? w_pos_w : (w_pos_w - PW'(1));
    assign w_ileft_w = w_cnt_w - w_idx_w;
    assign w_dleft_w = w_cnt_w - w_pos_w;
    assign w_cntm1_w = w_cnt_w - PW'(1);

    logic w_in_hs;
    logic w_out_hs;
    logic w_last;
    logic [CW-1:0] w_jn;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_hs         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_hs        = r_ovld && i_m_axis_tready;
    assign w_jn            = CW'(r_j) + CW'(1);
    assign w_last          = r_ev ? (w_jn == r_cnt) : 1'b1;

    // memory port select
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [VAL_W-1:0] w_wd;
    logic [AW-1:0]    w_ra;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_pdst;
        w_wd = r_rd;
        w_ra = r_j;
        case (r_state)
            S_IDLE: begin
                if (w_in_hs && w_chk.to_empty) begin
                    w_we = 1'b1;
                    w_wa = '0;
                    w_wd = w_value;
                end
            end
            S_SHIFT: begin
                w_we = r_pend;
                if (r_left != '0) begin
                    w_ra = r_src;
                end
            end
            S_FIN: begin
                w_we = r_ins;
                w_wa = r_idx;
                w_wd = r_val;
            end
            S_STREAM: begin
                if (w_out_hs && !w_last) begin
                    w_ra = r_j + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_hs) begin
            r_val <= w_value;
            r_idx <= w_idx_w[AW-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_src    <= '0;
            r_pdst   <= '0;
            r_pend   <= 1'b0;
            r_dir    <= 1'b0;
            r_ins    <= 1'b0;
            r_j      <= '0;
            r_ovld   <= 1'b0;
            r_ev     <= 1'b0;
            r_status <= ST_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_hs) begin
                        r_status <= w_chk.status;
                        r_j      <= '0;
                        r_pend   <= 1'b0;
                        if (!w_chk.ok) begin
                            r_ev    <= 1'b0;
                            r_ovld  <= 1'b1;
                            r_state <= S_STREAM;
                        end else if (w_chk.to_empty) begin
                            r_cnt   <= CW'(1);
                            r_state <= S_PRIME;
                        end else if (w_cmd == CMD_ADD) begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_ins   <= 1'b1;
                            r_dir   <= 1'b0;
                            r_left  <= w_ileft_w[CW-1:0];
                            r_src   <= w_cntm1_w[AW-1:0];
                            r_state <= S_SHIFT;
                        end else begin
                            r_cnt   <= r_cnt - CW'(1);
                            r_ins   <= 1'b0;
                            r_dir   <= 1'b1;
                            r_left  <= w_dleft_w[CW-1:0];
                            r_src   <= w_pos_w[AW-1:0];
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // one read issued and the previous read written per cycle
                    if (r_left != '0) begin
                        r_left <= r_left - CW'(1);
                        r_src  <= r_dir ? (r_src + AW'(1)) : (r_src - AW'(1));
                        r_pdst <= r_dir ? (r_src - AW'(1)) : (r_src + AW'(1));
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_ins <= 1'b0;
                    r_j   <= '0;
                    if (r_cnt == '0) begin
                        // emptied list: single marker result
                        r_ev    <= 1'b0;
                        r_ovld  <= 1'b1;
                        r_state <= S_STREAM;
                    end else begin
                        r_state <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    r_ev    <= 1'b1;
                    r_ovld  <= 1'b1;
                    r_state <= S_STREAM;
                end
                S_STREAM: begin
                    if (w_out_hs) begin
                        if (w_last) begin
                            r_ovld  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // outputs
    logic [PW-1:0]    w_cnt_out;
    logic [VAL_W-1:0] w_elem;

    assign w_cnt_out       = PW'(r_cnt);
    assign w_elem          = r_ev ? r_rd : '0;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {3'b000, w_cnt_out[POS_W-1:0], w_elem};
    assign o_m_axis_tuser  = {r_ev, r_status};
    assign o_m_axis_tlast  = w_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && r_ovld))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_hs |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after an input transaction");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_hs && o_m_axis_tlast) |=> (r_state == S_IDLE))
        else $error("sequencer not idle after final result");

    a_cnt_on_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> $past(w_in_hs))
        else $error("list count changed without an input transaction");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_positional_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// tb_positional_ordered_list_engine
// Self-checking bench for the positional ordered list engine.
// ----------------------------------------------------------------------------
// Drives add and delete commands on the slave stream and checks every master
// transaction against an in-bench list model. The model tracks the entries
// and the count, and queues the full head-to-tail listing (or the single
// error result) each command should produce. A directed opening covers the
// error codes, the empty and full cases and the value extremes. A random
// section then swings the list between empty and full. Both stream sides
// idle in random bursts, the receiver holds off once for a long stretch, and
// the sender waits once for a full drain. The tail of the run has no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_ordered_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import polist_pkg::*;

    localparam int          CAPACITY     = 16;
    localparam int          RAND_ITEMS   = 325;
    localparam int          QUIET_ITEMS  = 60;    // final random items, no idling
    localparam int          HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int          DRAIN_CYCLES = 50;    // idle margin after the final result
    localparam int          IDLE_LIMIT   = 2000;  // watchdog, cycles w/o transaction
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;

    // one master transaction as seen by the checker
    typedef struct packed {
        logic [1:0]  status;
        logic        elem_valid;
        logic [31:0] element;
        logic [4:0]  list_count;
        logic        last;
    } t_listing;

    // ------------------------------------------------------------------------
    // list model and result checker
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [31:0] entries [CAPACITY];
        int          count;
        t_listing    pending_listing[$];
        int          errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        task report(string what, longint got, longint want);
            $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
            errors++;
        endtask

        function void push(logic [1:0] st, logic ev, logic [31:0] el, logic lst);
            t_listing r;
            r.status     = st;
            r.elem_valid = ev;
            r.element    = el;
            r.list_count = count[4:0];
            r.last       = lst;
            pending_listing.push_back(r);
        endfunction

        // whole list head to tail; an emptied list gives one marker result
        function void push_listing();
            if (count == 0) begin
                push(ST_OK, 1'b0, '0, 1'b1);
            end else begin
                for (int i = 0; i < count; i++)
                    push(ST_OK, 1'b1, entries[i], (i + 1 == count));
            end
        endfunction

        // accepted slave transaction: update the list, queue its results
        function void apply_command(logic cmd, logic [31:0] val, logic [4:0] pos,
                                    logic aft);
            int idx;
            idx = 0;
            if (cmd == CMD_ADD) begin
                if (count >= CAPACITY) begin
                    push(ST_FULL, 1'b0, '0, 1'b1);          // full wins over position
                end else if (count == 0) begin
                    entries[0] = val;                      // position ignored
                    count      = 1;
                    push_listing();
                end else if (pos < 1 || pos > count) begin
                    push(ST_BAD_POS, 1'b0, '0, 1'b1);
                end else begin
                    idx = aft ? int'(pos) : int'(pos) - 1;
                    for (int i = count; i > idx; i--)
                        entries[i] = entries[i-1];
                    entries[idx] = val;
                    count++;
                    push_listing();
                end
            end else begin
                if (count == 0) begin
                    push(ST_EMPTY, 1'b0, '0, 1'b1);         // empty wins over position
                end else if (pos < 1 || pos > count) begin
                    push(ST_BAD_POS, 1'b0, '0, 1'b1);
                end else begin
                    for (int i = int'(pos) - 1; i + 1 < count; i++)
                        entries[i] = entries[i+1];
                    count--;
                    push_listing();
                end
            end
        endfunction

        task check_result(logic [39:0] tdata, logic [2:0] tuser, logic tlast);
            t_listing want;
            if (pending_listing.size() == 0) begin
                report("unexpected transaction, element", tdata[31:0], 0);
            end else begin
                want = pending_listing.pop_front();
                if (tuser[1:0] !== want.status)
                    report("status", tuser[1:0], want.status);
                if (tuser[2] !== want.elem_valid)
                    report("element_valid", tuser[2], want.elem_valid);
                if (tdata[31:0] !== want.element)
                    report("element", tdata[31:0], want.element);
                if (tdata[36:32] !== want.list_count)
                    report("list_count", tdata[36:32], want.list_count);
                if (tlast !== want.last)
                    report("tlast", tlast, want.last);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata  = '0;   // [31:0] value, [36:32] position, [37] after
    logic [0:0]  i_s_axis_tuser  = '0;   // [0] command
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;         // [31:0] element, [36:32] list_count
    logic [2:0]  o_m_axis_tuser;         // [1:0] status, [2] element_valid
    logic        o_m_axis_tlast;

    always #5 i_clk = ~i_clk;

    positional_ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    list_scoreboard sb = new();

    bit quiet    = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    // Offers one command and returns at the edge it is accepted. Valid is
    // left high so a back-to-back command needs no second assignment.
    task send_command(logic cmd, logic [31:0] val, logic [4:0] pos, logic aft);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, aft, pos, val};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.apply_command(cmd, val, pos, aft);
    endtask

    task pause_sender(int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 11));
    endtask

    // extremes turn up often, otherwise any 32-bit pattern
    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'd0;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // monitor: values sampled at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // watchdog: consecutive cycles with no transaction on either side
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_positional_ordered_list_engine: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit          grow;
        logic        cmd;
        logic [4:0]  pos;
        grow = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // add to empty, then delete it again: emptied list marker;
        // value and after are don't-care on delete
        send_command(CMD_ADD, 32'd5, 5'd0, 1'b0);          maybe_gap();
        send_command(CMD_DEL, 32'hffff_ffff, 5'd1, 1'b1); maybe_gap();
        // delete on empty, position bad as well: empty status wins
        send_command(CMD_DEL, VAL_MAX, 5'd0, 1'b0);        maybe_gap();
        send_command(CMD_DEL, VAL_MIN, 5'd16, 1'b1);       maybe_gap();
        // add to empty ignores position and after
        send_command(CMD_ADD, VAL_MIN, 5'd16, 1'b1);       maybe_gap();
        // bad positions on add: zero and above count
        send_command(CMD_ADD, 32'd1, 5'd0, 1'b0);          maybe_gap();
        send_command(CMD_ADD, 32'd1, 5'd2, 1'b1);          maybe_gap();
        // insert before head, after tail
        send_command(CMD_ADD, VAL_MAX, 5'd1, 1'b0);        maybe_gap();
        send_command(CMD_ADD, 32'd0, 5'd2, 1'b1);          maybe_gap();
        // bad positions on delete, then a middle delete
        send_command(CMD_DEL, 32'd0, 5'd0, 1'b0);          maybe_gap();
        send_command(CMD_DEL, 32'd0, 5'd4, 1'b0);          maybe_gap();
        send_command(CMD_DEL, 32'd0, 5'd2, 1'b0);          maybe_gap();
        // fill to capacity at random positions
        while (sb.count < CAPACITY) begin
            send_command(CMD_ADD, pick_value(), 5'($urandom_range(1, sb.count)),
                         1'($urandom_range(0, 1)));
            maybe_gap();
        end
        // full list: full status wins over a bad position
        send_command(CMD_ADD, VAL_MAX, 5'd0, 1'b1);        maybe_gap();
        send_command(CMD_ADD, VAL_MIN, 5'd16, 1'b0);       maybe_gap();
        // delete the tail of a full list
        send_command(CMD_DEL, 32'd0, 5'd16, 1'b0);         maybe_gap();

        // --- random: swing between empty and full ---
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (sb.count == CAPACITY && $urandom_range(0, 2) == 0)
                grow = 1'b0;
            else if (sb.count == 0 && $urandom_range(0, 2) == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 29) == 0)
                grow = ~grow;

            cmd = ($urandom_range(0, 99) < (grow ? 80 : 20)) ? CMD_ADD : CMD_DEL;
            // mostly legal positions, some noise over positions 0 to 16
            if (sb.count == 0 || $urandom_range(0, 7) == 0)
                pos = 5'($urandom_range(0, 16));
            else
                pos = 5'($urandom_range(1, sb.count));

            if (n == 100)
                hold_req = 1'b1;          // sender keeps offering meanwhile
            if (n == 200 && sb.pending_listing.size() != 0) begin
                // wait for a complete drain before the next command
                i_s_axis_tvalid <= 1'b0;
                while (sb.pending_listing.size() != 0) @(posedge i_clk);
            end
            if (n == RAND_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;

            send_command(cmd, pick_value(), pos, 1'($urandom_range(0, 1)));
            maybe_gap();
        end

        // --- drain and verdict ---
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_listing.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb_positional_ordered_list_engine: done, clean");
        else
            $display("tb_positional_ordered_list_engine: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/polist_pkg.sv
sv/polist_chk.sv
sv/positional_ordered_list_engine.sv
bench/tb_positional_ordered_list_engine.sv
